// File: rtl/lti_pkg.sv
// shared types, constants and codes for the linear table interpolator
// no dependencies; every other file in rtl/ except lti_ram.sv imports this package

package lti_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // serial divider: quotient fits 32 bits, one bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_POINT_COUNT = 1'b0;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result regions
  localparam logic [1:0] REGION_FIRST    = 2'd0;
  localparam logic [1:0] REGION_INTERIOR = 2'd1;
  localparam logic [1:0] REGION_ABOVE    = 2'd2;
  localparam logic [1:0] REGION_NONE     = 2'd3;

  // input transaction payload
  typedef struct packed {
    logic               opcode;
    logic [5:0]         entry_index;
    logic [31:0]        breakpoint;
    logic signed [31:0] entry_value;
    logic [31:0]        query_position;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         region;
  } out_item_t;

  // classification made by the front
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DROP,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   addr;
    logic [31:0]        pos;
    logic signed [31:0] value;
  } q_entry_t;

  // head of the queue as seen by the back
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/linear_table_interpolator.sv
// top level of the piecewise-linear table interpolator
// depends on lti_pkg, lti_front and lti_back
//
// Usage: the input channel carries load and query transactions; a load writes one
// breakpoint/value pair, a query returns one interpolated value with its region on
// the output channel. Results come back in query order; loads give no result.
// The APB port holds point_count at byte address 0 (reset value 1); the user must
// write it only while the block is idle, which the block itself does not enforce.
// Flow: a two-entry queue parts the front from the back, so up to
// two transactions are taken while the back is busy. The back handles one
// transaction at a time and, when idle, takes it from the queue in the cycle after
// acceptance. A load writes the table in the cycle it is taken; a query reads entry
// zero and gives its value if it clamps below the first point, else reads the last
// entry and gives its value if it clamps above. An interior query scans the table
// one ram read a cycle (up to n-1 reads, n being point_count clamped to 1..64),
// then multiplies, starts the divider and waits on its 32 steps; each result then
// passes to the output register.
// Reset clears the queue, the sequencer and the output valid; the table is not
// cleared and an entry must be loaded before a query reads it.
// A stalled result holds in the output register; the back waits with the next
// result, and the queue stalls the input when full.

module linear_table_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lti_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lti_pkg::out_item_t                out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lti_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  import lti_pkg::*;

  logic [6:0] point_count_r;
  logic       cfg_wr;
  q_head_t    head;
  logic       pop;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_POINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 7'd1;
    end else if (cfg_wr) begin
      point_count_r <= cfg_pwdata[6:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_POINT_COUNT) ? {25'b0, point_count_r} : 32'd0;

  // accept and classify
  lti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // execute
  lti_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_count (point_count_r),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: rtl/lti_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module lti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lti_front.sv
// front end: accepts input transactions, classifies them and queues them
// depends on lti_pkg

module lti_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lti_pkg::in_item_t in_data,
  output lti_pkg::q_head_t  head,
  input  logic              pop
);

  import lti_pkg::*;

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              do_pop;
  q_entry_t          cls;

  // classify the incoming transaction
  always_comb begin
    cls.addr  = IDX_W'(in_data.entry_index);
    cls.value = in_data.entry_value;
    if (in_data.opcode == OP_QUERY) begin
      cls.kind = KIND_QUERY;
      cls.pos  = in_data.query_position;
    end else begin
      cls.pos  = in_data.breakpoint;
      if (32'(in_data.entry_index) < 32'(TABLE_DEPTH)) begin
        cls.kind = KIND_LOAD;
      end else begin
        cls.kind = KIND_DROP;
      end
    end
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/lti_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
// depends on lti_pkg

module lti_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lti_pkg::div_req_t req,
  output lti_pkg::div_rsp_t rsp
);

  import lti_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [31:0]       rem_r;
  logic [31:0]       lo_r;
  logic [31:0]       div_r;
  logic [32:0]       trial;
  logic [32:0]       diff;
  logic              ge;
  logic [31:0]       rem_step;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, lo_r[31]};
    diff     = trial - {1'b0, div_r};
    ge       = (trial >= {1'b0, div_r});
    rem_step = ge ? diff[31:0] : trial[31:0];
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = lo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; the high dividend half is below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[63:32];
      lo_r  <= req.dividend[31:0];
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      lo_r  <= {lo_r[30:0], ge};
    end
  end

endmodule

// File: rtl/lti_back.sv
// back end: executes queued loads and queries against the table ram
// depends on lti_pkg, lti_ram and lti_div

module lti_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         point_count,
  input  lti_pkg::q_head_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lti_pkg::out_item_t out_data
);

  import lti_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DIVST,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [31:0]        x_prev_r, x_prev_nxt;
  logic signed [31:0] y_prev_r, y_prev_nxt;
  logic signed [31:0] y_last_r, y_last_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [31:0]        dx_r, dx_nxt;
  logic [31:0]        dq_r, dq_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [1:0]         reg_r, reg_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [63:0]        ram_rdata;
  logic [31:0]        rd_x;
  logic signed [31:0] rd_y;
  logic               hit;

  logic [31:0]        pc_ext;
  logic [31:0]        n_used;
  logic [IDX_W-1:0]   last_idx;
  logic               multi;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // table: breakpoint in the upper half, value in the lower half
  lti_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.entry.addr),
    .wdata ({head.entry.pos, head.entry.value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rd_x = ram_rdata[63:32];
  assign rd_y = ram_rdata[31:0];

  // points in use, clamped to one and to the table depth
  always_comb begin
    pc_ext = {25'b0, point_count};
    if (pc_ext == 32'd0) begin
      n_used = 32'd1;
    end else if (pc_ext > 32'(TABLE_DEPTH)) begin
      n_used = 32'(TABLE_DEPTH);
    end else begin
      n_used = pc_ext;
    end
    last_idx = IDX_W'(n_used - 32'd1);
    multi    = (n_used >= 32'd2);
  end

  assign hit = (q_r >= x_prev_r) && (q_r <= rd_x);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    q_nxt            = q_r;
    x_prev_nxt       = x_prev_r;
    y_prev_nxt       = y_prev_r;
    y_last_nxt       = y_last_r;
    cnt_nxt          = cnt_r;
    dx_nxt           = dx_r;
    dq_nxt           = dq_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    prod_nxt         = prod_r;
    res_nxt          = res_r;
    reg_nxt          = reg_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_item_nxt     = out_item_r;
    pop              = 1'b0;
    ram_we           = 1'b0;
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = dx_r;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.entry.kind)
            KIND_LOAD: begin
              ram_we = 1'b1;
            end
            KIND_QUERY: begin
              q_nxt     = head.entry.pos;
              ram_raddr = '0;
              state_nxt = S_FIRST;
            end
            default: begin
              // out-of-range load index: nothing to do
            end
          endcase
        end
      end

      // entry zero is on the read port
      S_FIRST: begin
        x_prev_nxt = rd_x;
        y_prev_nxt = rd_y;
        if (!multi || (q_r <= rd_x)) begin
          res_nxt   = rd_y;
          reg_nxt   = REGION_FIRST;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = last_idx;
          state_nxt = S_LAST;
        end
      end

      // last entry is on the read port
      S_LAST: begin
        if (q_r >= rd_x) begin
          res_nxt   = rd_y;
          reg_nxt   = REGION_ABOVE;
          state_nxt = S_DONE;
        end else begin
          y_last_nxt = rd_y;
          ram_raddr  = IDX_W'(1);
          cnt_nxt    = IDX_W'(1);
          state_nxt  = S_SCAN;
        end
      end

      // entry cnt_r on the read port, entry cnt_r-1 held in x_prev/y_prev
      S_SCAN: begin
        if (hit) begin
          neg_nxt = (rd_y < y_prev_r);
          mag_nxt = (rd_y < y_prev_r) ? 32'(y_prev_r - rd_y) : 32'(rd_y - y_prev_r);
          dx_nxt  = rd_x - x_prev_r;
          dq_nxt  = q_r - x_prev_r;
          reg_nxt = REGION_INTERIOR;
          if (rd_x == x_prev_r) begin
            res_nxt   = y_prev_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (cnt_r == last_idx) begin
          res_nxt   = y_last_r;
          reg_nxt   = REGION_NONE;
          state_nxt = S_DONE;
        end else begin
          x_prev_nxt = rd_x;
          y_prev_nxt = rd_y;
          cnt_nxt    = cnt_r + 1'b1;
          ram_raddr  = cnt_r + 1'b1;
        end
      end

      S_MUL: begin
        prod_nxt  = dq_r * mag_r;
        state_nxt = S_DIVST;
      end

      S_DIVST: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end

      // quotient lies between zero and the value step, so no overflow
      S_DIV: begin
        if (div_rsp.done) begin
          if (neg_r) begin
            res_nxt = y_prev_r - $signed(div_rsp.quotient);
          end else begin
            res_nxt = y_prev_r + $signed(div_rsp.quotient);
          end
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.result_value = res_r;
          out_item_nxt.region       = reg_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r        <= q_nxt;
    x_prev_r   <= x_prev_nxt;
    y_prev_r   <= y_prev_nxt;
    y_last_r   <= y_last_nxt;
    cnt_r      <= cnt_nxt;
    dx_r       <= dx_nxt;
    dq_r       <= dq_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    reg_r      <= reg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
